@@ rtl/core/jos_pkg.sv @@
// package for the json object splitter core: beat types, offset limit, byte codes
// no dependencies; imported by every module of the core
`timescale 1ns / 1ps

package jos_pkg;

    // text size the offset counter covers, limit is capped at 16-bit offsets
    localparam longint unsigned TEXT_BYTES = 64'd65536;
    localparam longint unsigned LIMIT_FULL = (TEXT_BYTES < 64'd65536) ? TEXT_BYTES : 64'd65536;
    localparam logic [16:0]     OFFSET_LIMIT = LIMIT_FULL[16:0];
    localparam logic [15:0]     OFFSET_MAX   = 16'(LIMIT_FULL - 64'd1);

    // nesting depth saturation points
    localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;

    // byte codes that steer the parse
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_OPEN      = 8'h7B;
    localparam logic [7:0] CH_CLOSE     = 8'h7D;

    // one input beat
    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_of_text;
    } t_item;

    // one result beat
    typedef struct packed {
        logic [15:0] object_first;
        logic [15:0] object_last;
        logic        offset_overflow;
    } t_result;

endpackage

@@ rtl/core/json_object_splitter_core.sv @@
// top level of the json object splitter core: input register, parser, result register
// depends on jos_pkg, jos_in_reg, jos_parse and jos_out_reg
`timescale 1ns / 1ps

// Usage
// The slave channel takes one byte of a JSON array text per beat: tdata holds
// the byte, tuser set marks the first byte of a new text and clears all parse
// state ahead of it. The master channel gives one beat for every top-level
// object that closes: tdata holds the offsets of its opening and closing brace,
// tuser flags that the text ran past the 65536-byte offset range so offsets
// were saturated. Bytes that close no object give no beat.
// Path: a closing brace accepted on the slave side waits in the input register,
// passes the parser update and is then held in the result register.
// Throughput: one byte per cycle, set by the combinational parser update
// between the two registers; the input side keeps taking bytes while a result
// waits, as long as those bytes close no further object.
// Stall: with a result held and the receiver not ready, a byte that would
// close another object waits in the input register and the slave tready drops.
// Reset clears offset, depth, string and backslash state and empties both
// registers; the next byte is at offset zero.

module json_object_splitter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] text_byte
    input  logic        i_s_tuser,  // [0] start_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [15:0] object_first, [31:16] object_last
    output logic        o_m_tuser   // [0] offset_overflow
);
    import jos_pkg::*;

    t_item   in_item;
    t_item   s1_item;
    logic    s1_valid;
    logic    advance;
    logic    hit;
    logic    out_free;
    t_result res;
    t_result out_res;

    assign in_item.text_byte     = i_s_tdata;
    assign in_item.start_of_text = i_s_tuser;

    // a byte moves on unless it closes an object while the result slot is full and not taken
    assign advance = s1_valid && (!hit || out_free);

    jos_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    jos_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .i_item   (s1_item),
        .i_update (advance),
        .o_hit    (hit),
        .o_res    (res)
    );

    jos_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && hit),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    // result beat packing
    assign o_m_tdata = {out_res.object_last, out_res.object_first};
    assign o_m_tuser = out_res.offset_overflow;

    // opening brace never lies after its closing brace
    a_first_le_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:0] <= o_m_tdata[31:16]))
        else $error("object_first after object_last");

    // overflow results carry the saturated closing offset
    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[31:16] == OFFSET_MAX))
        else $error("overflow result with unsaturated offset");

    // a stalled byte stays in the input register
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
        else $error("stalled byte lost");

    // a result is only loaded into a free slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && hit) |-> out_free)
        else $error("result register overwritten");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

@@ rtl/core/jos_in_reg.sv @@
// input register of the json object splitter: holds one text byte beat
// depends on jos_pkg for the beat type
`timescale 1ns / 1ps

module jos_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  jos_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output jos_pkg::t_item o_item
);
    import jos_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    // a slot is free when empty or when its beat moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign n_valid = i_valid || (r_valid && !i_advance);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/core/jos_parse.sv @@
// parse state and per-byte update of the json object splitter
// depends on jos_pkg for byte codes, limits and beat types
`timescale 1ns / 1ps

module jos_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  jos_pkg::t_item   i_item,
    input  logic             i_update,
    output logic             o_hit,
    output jos_pkg::t_result o_res
);
    import jos_pkg::*;

    logic [16:0]        r_offset;
    logic               r_in_str;
    logic               r_odd_bs;
    logic signed [15:0] r_depth;
    logic [15:0]        r_open_off;
    logic               r_open_vld;

    logic [16:0]        n_offset;
    logic               n_in_str;
    logic               n_odd_bs;
    logic signed [15:0] n_depth;
    logic [15:0]        n_open_off;
    logic               n_open_vld;

    logic [16:0]        cur_offset;
    logic               cur_in_str;
    logic               cur_odd_bs;
    logic signed [15:0] cur_depth;
    logic [15:0]        cur_open_off;
    logic               cur_open_vld;
    logic               over;
    logic [15:0]        here;
    logic               hit;

    // start of text clears state ahead of this byte
    always_comb begin
        if (i_item.start_of_text) begin
            cur_offset   = '0;
            cur_in_str   = 1'b0;
            cur_odd_bs   = 1'b0;
            cur_depth    = '0;
            cur_open_off = '0;
            cur_open_vld = 1'b0;
        end else begin
            cur_offset   = r_offset;
            cur_in_str   = r_in_str;
            cur_odd_bs   = r_odd_bs;
            cur_depth    = r_depth;
            cur_open_off = r_open_off;
            cur_open_vld = r_open_vld;
        end
    end

    // offset of this byte, saturated at the limit
    assign over     = (cur_offset >= OFFSET_LIMIT);
    assign here     = over ? OFFSET_MAX : cur_offset[15:0];
    assign n_offset = over ? cur_offset : cur_offset + 17'd1;

    // string tracking and backslash parity
    assign n_in_str = (i_item.text_byte == CH_QUOTE && !cur_odd_bs) ? !cur_in_str : cur_in_str;
    assign n_odd_bs = (i_item.text_byte == CH_BACKSLASH) ? !cur_odd_bs : 1'b0;

    // brace nesting outside strings
    always_comb begin
        n_depth    = cur_depth;
        n_open_off = cur_open_off;
        n_open_vld = cur_open_vld;
        hit        = 1'b0;
        if (!n_in_str) begin
            if (i_item.text_byte == CH_OPEN) begin
                if (cur_depth == 16'sd0) begin
                    n_open_off = here;
                    n_open_vld = 1'b1;
                end
                if (cur_depth != DEPTH_MAX) begin
                    n_depth = cur_depth + 16'sd1;
                end
            end else if (i_item.text_byte == CH_CLOSE) begin
                if (cur_depth != DEPTH_MIN) begin
                    n_depth = cur_depth - 16'sd1;
                end
                if (cur_depth == 16'sd1 && cur_open_vld) begin
                    hit        = 1'b1;
                    n_open_vld = 1'b0;
                end
            end
        end
    end

    assign o_hit                 = i_valid && hit;
    assign o_res.object_first    = cur_open_off;
    assign o_res.object_last     = here;
    assign o_res.offset_overflow = over;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_in_str   <= 1'b0;
            r_odd_bs   <= 1'b0;
            r_depth    <= '0;
            r_open_vld <= 1'b0;
        end else if (i_update) begin
            r_offset   <= n_offset;
            r_in_str   <= n_in_str;
            r_odd_bs   <= n_odd_bs;
            r_depth    <= n_depth;
            r_open_vld <= n_open_vld;
        end
    end

    // recorded brace offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_off <= '0;
        end else if (i_update) begin
            r_open_off <= n_open_off;
        end
    end

endmodule

@@ rtl/core/jos_out_reg.sv @@
// result register of the json object splitter: holds one object beat
// depends on jos_pkg for the result type
`timescale 1ns / 1ps

module jos_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jos_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output jos_pkg::t_result o_res
);
    import jos_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    n_valid;

    // free when empty or when the held beat is taken now
    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
